// File: rtl/core/ndr_pkg.sv
// Types and constants shared by the NDEF record deframer modules.
package ndr_pkg;

  // Flag byte bit positions.
  localparam int unsigned FlagMeBit = 6;
  localparam int unsigned FlagSrBit = 4;
  localparam int unsigned FlagIlBit = 3;
  localparam int unsigned TnfMsb    = 2;

  // Section codes on the result.
  localparam logic [2:0] SecHeader  = 3'd0;
  localparam logic [2:0] SecType    = 3'd1;
  localparam logic [2:0] SecId      = 3'd2;
  localparam logic [2:0] SecPayload = 3'd3;
  localparam logic [2:0] SecIgnored = 3'd4;

  localparam logic [7:0] MaxRecordsReset = 8'd4;
  localparam logic [7:0] RecordCountMax  = 8'd255;

  // Long form carries four length bytes; counter holds bytes still due minus one.
  localparam logic [1:0] LongLenCount = 2'd3;

  // Request on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ndr_in_t;

  // Request on the output channel.
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] section;
    logic [2:0] record_tnf;
    logic [7:0] record_number;
    logic       record_end;
    logic       message_end;
    logic       record_dropped;
    logic       truncated;
  } ndr_out_t;

  // Byte after front-end decode, as queued for the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       me;
    logic       sr;
    logic       il;
    logic [2:0] tnf;
  } ndr_entry_t;

endpackage

// File: rtl/core/ndef_record_deframer.sv
// NDEF record deframer top level: front-end byte queue feeding the record parser.
// Each byte passes through the queue, then the result register, on its way to the output.
// Throughput: 1 byte per cycle while unstalled; the parser consumes one queued byte a cycle.
// A 2-entry queue between front and back lets input and output stall independently.
// Reset (rst_ni low, async): parser expects a flag byte, counters clear, queue and
// result stage empty, max_records returns to 4.
module ndef_record_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  // max_records configuration write
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  // byte input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ndr_pkg::ndr_in_t  in_req_i,
  // tagged byte output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ndr_pkg::ndr_out_t out_req_o
);

  // Queue handshake between the two halves.
  logic                q_valid;
  logic                q_pop;
  ndr_pkg::ndr_entry_t q_entry;

  // Front: takes each request, splits out the flag fields and queues it.
  ndr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  // Back: walks header, type, id and payload, tags each byte and registers
  // the result; it pops the queue whenever its result register can move.
  ndr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: rtl/core/ndr_front.sv
// Front end: accepts bytes, decodes flag fields, queues them for the parser.
module ndr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ndr_pkg::ndr_in_t   in_req_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output ndr_pkg::ndr_entry_t q_entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ndr_pkg::ndr_entry_t entry_d;
  ndr_pkg::ndr_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop, full;

  // Decode is unconditional; only the flag-byte phase uses the flag fields.
  always_comb begin
    entry_d.data_byte = in_req_i.data_byte;
    entry_d.last_byte = in_req_i.last_byte;
    entry_d.me        = in_req_i.data_byte[ndr_pkg::FlagMeBit];
    entry_d.sr        = in_req_i.data_byte[ndr_pkg::FlagSrBit];
    entry_d.il        = in_req_i.data_byte[ndr_pkg::FlagIlBit];
    entry_d.tnf       = in_req_i.data_byte[ndr_pkg::TnfMsb:0];
  end

  assign full       = (count_q == CntW'(Depth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

endmodule

// File: rtl/core/ndr_back.sv
// Back end: record parser state machine with registered result stage.
module ndr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  ndr_pkg::ndr_entry_t q_entry_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ndr_pkg::ndr_out_t   out_req_o
);

  localparam logic [2:0] PhFlag    = 3'd0;
  localparam logic [2:0] PhTypeLen = 3'd1;
  localparam logic [2:0] PhPlen    = 3'd2;
  localparam logic [2:0] PhIdLen   = 3'd3;
  localparam logic [2:0] PhType    = 3'd4;
  localparam logic [2:0] PhId      = 3'd5;
  localparam logic [2:0] PhPayload = 3'd6;
  localparam logic [2:0] PhDone    = 3'd7;

  logic [7:0]  max_q;
  logic [2:0]  phase_q, phase_d;
  logic        me_q, me_d, sr_q, sr_d, il_q, il_d;
  logic [2:0]  tnf_q, tnf_d;
  logic [7:0]  type_rem_q, type_rem_d;
  logic [7:0]  id_rem_q, id_rem_d;
  logic [31:0] pay_rem_q, pay_rem_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic [7:0]  rec_cnt_q, rec_cnt_d;

  logic              out_valid_q;
  ndr_pkg::ndr_out_t out_q, out_d;

  logic       take;
  logic       do_check, rec_end, ignored, msg_end;
  logic [2:0] sec;
  logic [7:0] b;

  // Result stage frees up when empty or when its request leaves this cycle.
  assign take        = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign b           = q_entry_i.data_byte;

  always_comb begin
    phase_d    = phase_q;
    me_d       = me_q;
    sr_d       = sr_q;
    il_d       = il_q;
    tnf_d      = tnf_q;
    type_rem_d = type_rem_q;
    id_rem_d   = id_rem_q;
    pay_rem_d  = pay_rem_q;
    len_cnt_d  = len_cnt_q;
    rec_cnt_d  = rec_cnt_q;
    do_check   = 1'b0;
    rec_end    = 1'b0;
    ignored    = 1'b0;
    msg_end    = 1'b0;
    sec        = ndr_pkg::SecHeader;

    case (phase_q)
      PhTypeLen: begin
        type_rem_d = b;
        phase_d    = PhPlen;
      end
      PhPlen: begin
        pay_rem_d = {pay_rem_q[23:0], b};
        if (len_cnt_q == 2'd0) begin
          if (il_q) begin
            phase_d = PhIdLen;
          end else begin
            do_check = 1'b1;
          end
        end else begin
          len_cnt_d = len_cnt_q - 2'd1;
        end
      end
      PhIdLen: begin
        id_rem_d = b;
        do_check = 1'b1;
      end
      PhType: begin
        sec        = ndr_pkg::SecType;
        type_rem_d = type_rem_q - 8'd1;
        do_check   = 1'b1;
      end
      PhId: begin
        sec      = ndr_pkg::SecId;
        id_rem_d = id_rem_q - 8'd1;
        do_check = 1'b1;
      end
      PhPayload: begin
        sec       = ndr_pkg::SecPayload;
        pay_rem_d = pay_rem_q - 32'd1;
        do_check  = 1'b1;
      end
      PhDone: begin
        sec     = ndr_pkg::SecIgnored;
        ignored = 1'b1;
      end
      default: begin
        me_d       = q_entry_i.me;
        sr_d       = q_entry_i.sr;
        il_d       = q_entry_i.il;
        tnf_d      = q_entry_i.tnf;
        type_rem_d = '0;
        id_rem_d   = '0;
        pay_rem_d  = '0;
        len_cnt_d  = q_entry_i.sr ? 2'd0 : ndr_pkg::LongLenCount;
        phase_d    = PhTypeLen;
      end
    endcase

    // Skip empty sections; record ends when nothing is left.
    if (do_check) begin
      if (type_rem_d != '0) begin
        phase_d = PhType;
      end else if (id_rem_d != '0) begin
        phase_d = PhId;
      end else if (pay_rem_d != '0) begin
        phase_d = PhPayload;
      end else begin
        rec_end = 1'b1;
      end
    end

    if (rec_end) begin
      msg_end = me_q;
      if (rec_cnt_q != ndr_pkg::RecordCountMax) begin
        rec_cnt_d = rec_cnt_q + 8'd1;
      end
      phase_d = me_q ? PhDone : PhFlag;
    end

    out_d.byte_out = b;
    out_d.section  = sec;
    if (ignored) begin
      out_d.record_tnf     = '0;
      out_d.record_number  = '0;
      out_d.record_end     = 1'b0;
      out_d.message_end    = 1'b0;
      out_d.record_dropped = 1'b0;
      out_d.truncated      = 1'b0;
    end else begin
      out_d.record_tnf     = tnf_d;
      out_d.record_number  = rec_cnt_q;
      out_d.record_end     = rec_end;
      out_d.message_end    = msg_end;
      out_d.record_dropped = (rec_cnt_q >= max_q);
      out_d.truncated      = q_entry_i.last_byte && !rec_end;
    end

    // End of buffer: start over on a fresh message.
    if (q_entry_i.last_byte) begin
      phase_d    = PhFlag;
      me_d       = 1'b0;
      sr_d       = 1'b0;
      il_d       = 1'b0;
      tnf_d      = '0;
      type_rem_d = '0;
      id_rem_d   = '0;
      pay_rem_d  = '0;
      len_cnt_d  = '0;
      rec_cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= ndr_pkg::MaxRecordsReset;
      phase_q     <= PhFlag;
      me_q        <= 1'b0;
      sr_q        <= 1'b0;
      il_q        <= 1'b0;
      tnf_q       <= '0;
      type_rem_q  <= '0;
      id_rem_q    <= '0;
      pay_rem_q   <= '0;
      len_cnt_q   <= '0;
      rec_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (take) begin
        phase_q    <= phase_d;
        me_q       <= me_d;
        sr_q       <= sr_d;
        il_q       <= il_d;
        tnf_q      <= tnf_d;
        type_rem_q <= type_rem_d;
        id_rem_q   <= id_rem_d;
        pay_rem_q  <= pay_rem_d;
        len_cnt_q  <= len_cnt_d;
        rec_cnt_q  <= rec_cnt_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

// File: tb/ndr_tb_pkg.sv
// Byte-tag predictor and scoreboard for the NDEF record deframer testbench.
package ndr_tb_pkg;
  import ndr_pkg::*;

  typedef enum logic [3:0] {
    PhFlag, PhTypeLen, PhPayLen, PhIdLen, PhType, PhId, PhPayload, PhDone
  } parse_phase_e;

  class ndef_tag_tracker;
    logic [7:0]   max_records = MaxRecordsReset;
    parse_phase_e phase       = PhFlag;
    logic         me_f        = 1'b0;
    logic         sr_f        = 1'b0;
    logic         il_f        = 1'b0;
    logic [2:0]   tnf         = '0;
    logic [7:0]   type_left   = '0;
    logic [7:0]   id_left     = '0;
    logic [31:0]  pay_left    = '0;
    logic [1:0]   len_left    = '0;
    logic [7:0]   rec_count   = '0;
    ndr_out_t     tags_due[$];
    int unsigned  mismatches     = 0;
    int unsigned  checked        = 0;
    int unsigned  records_closed = 0;
    int unsigned  truncations    = 0;
    int unsigned  ignored_bytes  = 0;

    // end of buffer: fresh message, register kept
    function void restart();
      phase     = PhFlag;
      me_f      = 1'b0;
      sr_f      = 1'b0;
      il_f      = 1'b0;
      tnf       = '0;
      type_left = '0;
      id_left   = '0;
      pay_left  = '0;
      len_left  = '0;
      rec_count = '0;
    endfunction

    // step to first non-empty body section; 1 when the record is done
    function bit next_body();
      if (type_left != 8'd0) begin
        phase = PhType;
        return 1'b0;
      end
      if (id_left != 8'd0) begin
        phase = PhId;
        return 1'b0;
      end
      if (pay_left != 32'd0) begin
        phase = PhPayload;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void absorb_byte(ndr_in_t req);
      ndr_out_t   want;
      logic [7:0] b;
      logic       done_rec;
      logic       msg_done;
      logic       skip;
      logic [2:0] sec;
      logic [7:0] rnum;
      b        = req.data_byte;
      done_rec = 1'b0;
      msg_done = 1'b0;
      skip     = 1'b0;
      sec      = SecHeader;
      rnum     = rec_count;
      case (phase)
        PhTypeLen: begin
          type_left = b;
          phase     = PhPayLen;
        end
        PhPayLen: begin
          pay_left = {pay_left[23:0], b};
          if (len_left == 2'd0) begin
            if (il_f) phase = PhIdLen;
            else done_rec = next_body();
          end else begin
            len_left = len_left - 2'd1;
          end
        end
        PhIdLen: begin
          id_left  = b;
          done_rec = next_body();
        end
        PhType: begin
          sec       = SecType;
          type_left = type_left - 8'd1;
          done_rec  = next_body();
        end
        PhId: begin
          sec      = SecId;
          id_left  = id_left - 8'd1;
          done_rec = next_body();
        end
        PhPayload: begin
          sec      = SecPayload;
          pay_left = pay_left - 32'd1;
          done_rec = next_body();
        end
        PhDone: begin
          sec  = SecIgnored;
          skip = 1'b1;
        end
        default: begin
          me_f      = b[FlagMeBit];
          sr_f      = b[FlagSrBit];
          il_f      = b[FlagIlBit];
          tnf       = b[TnfMsb:0];
          type_left = '0;
          id_left   = '0;
          pay_left  = '0;
          len_left  = sr_f ? 2'd0 : LongLenCount;
          phase     = PhTypeLen;
        end
      endcase
      if (done_rec) begin
        msg_done = me_f;
        if (rec_count != RecordCountMax) rec_count = rec_count + 8'd1;
        phase = msg_done ? PhDone : PhFlag;
        records_closed++;
      end
      want          = '0;
      want.byte_out = b;
      want.section  = sec;
      if (skip) begin
        ignored_bytes++;
      end else begin
        want.record_tnf     = tnf;
        want.record_number  = rnum;
        want.record_end     = done_rec;
        want.message_end    = msg_done;
        want.record_dropped = (rnum >= max_records);
        want.truncated      = req.last_byte && !done_rec;
        if (want.truncated) truncations++;
      end
      tags_due = {tags_due, want};
      if (req.last_byte) restart();
    endfunction

    function int unsigned pending();
      return tags_due.size();
    endfunction

    function void cmp_field(string fld, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
      end
    endfunction

    function void match_tagged_byte(ndr_out_t got);
      ndr_out_t want;
      if (tags_due.size() == 0) begin
        mismatches++;
        $display("%0t: tagged byte with none due, expected nothing actual %h", $time, got);
        return;
      end
      want = tags_due.pop_front();
      checked++;
      cmp_field("byte_out", want.byte_out, got.byte_out);
      cmp_field("section", 8'(want.section), 8'(got.section));
      cmp_field("record_tnf", 8'(want.record_tnf), 8'(got.record_tnf));
      cmp_field("record_number", want.record_number, got.record_number);
      cmp_field("record_end", 8'(want.record_end), 8'(got.record_end));
      cmp_field("message_end", 8'(want.message_end), 8'(got.message_end));
      cmp_field("record_dropped", 8'(want.record_dropped), 8'(got.record_dropped));
      cmp_field("truncated", 8'(want.truncated), 8'(got.truncated));
    endfunction
  endclass

endpackage

// File: tb/tb.sv
// Top-level testbench for the NDEF record deframer: stimulus, handshakes and final verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ndr_pkg::*;
  import ndr_tb_pkg::*;

  // generous bound for the slowest idle pattern
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SegBytes   = 40;
  localparam int unsigned SatRecords = 258;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  ndr_in_t    in_req    = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ndr_out_t   out_req;

  // idle odds in percent; sender idles first lightly, receiver heavily
  int unsigned send_idle_pct  = 6;
  int unsigned recv_stall_pct = 68;
  int unsigned bytes_sent     = 0;
  int unsigned buffers_sent   = 0;
  int unsigned cycles         = 0;

  logic [7:0]      frame_bytes[$];
  ndef_tag_tracker tracker;

  ndef_record_deframer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // result monitor: values read here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_tagged_byte(out_req);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d tagged bytes still due", cycles,
               tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request: optional idle cycles, then hold valid until accepted.
  // Valid stays high into the next request unless that one idles first.
  task automatic send_byte(logic [7:0] b, logic last);
    ndr_in_t req;
    req.data_byte = b;
    req.last_byte = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.absorb_byte(req);
    bytes_sent++;
  endtask

  // ship the staged buffer, last_byte on its final byte
  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    buffers_sent++;
    frame_bytes.delete();
  endtask

  // sender holds off until every tagged byte is back, then pipeline latency margin
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_records(logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.max_records = v;
  endtask

  // Header: flag byte (MB and CF random, never looked at), type length,
  // payload length short or big-endian long, id length when IL is set.
  function automatic void push_header(bit me, bit sr, bit il, logic [2:0] tnf,
                                      logic [7:0] tlen, logic [7:0] ilen,
                                      logic [31:0] plen);
    logic mb;
    logic cf;
    mb = 1'($urandom_range(0, 1));
    cf = 1'($urandom_range(0, 1));
    frame_bytes = {frame_bytes, {mb, me, cf, sr, il, tnf}};
    frame_bytes = {frame_bytes, tlen};
    if (sr) begin
      frame_bytes = {frame_bytes, plen[7:0]};
    end else begin
      frame_bytes = {frame_bytes, plen[31:24]};
      frame_bytes = {frame_bytes, plen[23:16]};
      frame_bytes = {frame_bytes, plen[15:8]};
      frame_bytes = {frame_bytes, plen[7:0]};
    end
    if (il) frame_bytes = {frame_bytes, ilen};
  endfunction

  function automatic void push_body(int unsigned n);
    repeat (n) frame_bytes = {frame_bytes, 8'($urandom)};
  endfunction

  // Mostly tiny sections, zero lengths common; a few at 255 to hit counter extremes.
  function automatic void push_record(bit me);
    bit          sr;
    bit          il;
    logic [2:0]  tnf;
    int unsigned tlen;
    int unsigned ilen;
    int unsigned plen;
    sr   = ($urandom_range(0, 3) != 0);
    il   = 1'($urandom_range(0, 1));
    tnf  = 3'($urandom_range(0, 7));
    tlen = ($urandom_range(0, 99) < 3) ? 255 : $urandom_range(0, 3);
    ilen = !il ? 0 : ($urandom_range(0, 99) < 3) ? 255 : $urandom_range(0, 3);
    plen = ($urandom_range(0, 99) < 3) ? 255 : $urandom_range(0, 8);
    push_header(me, sr, il, tnf, 8'(tlen), 8'(ilen), plen);
    push_body(tlen + ilen + plen);
  endfunction

  // Well-formed message; ME on the last record when closed, maybe trailing
  // bytes that should come back as ignored. Unclosed: buffer ends after a
  // complete record without ME.
  function automatic void push_message(bit closed);
    int unsigned nrec;
    nrec = $urandom_range(1, 6);
    for (int i = 0; i < nrec; i++) push_record(closed && (i == nrec - 1));
    if (closed && $urandom_range(0, 99) < 30) push_body($urandom_range(1, 3));
  endfunction

  task automatic send_random_buffer();
    int unsigned k;
    int unsigned cut;
    k = $urandom_range(0, 99);
    if (k < 72) begin
      push_message($urandom_range(0, 19) != 0);
    end else if (k < 86) begin
      // buffer ends mid-message
      push_message(1'b1);
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else if (k < 94) begin
      // long-form header with a random 32-bit length, cut early
      push_header(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, 7)), 8'd0, 8'($urandom_range(0, 2)), $urandom);
      push_body($urandom_range(0, 6));
    end else begin
      // raw noise
      push_body($urandom_range(1, 8));
    end
    send_frame();
    // occasional full drain mid-stream
    if ($urandom_range(0, 99) < 6) settle();
  endtask

  initial begin
    logic [7:0]  mr;
    int unsigned seg_goal;
    tracker = new;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // Directed, max_records at reset value.
    // All-empty record with ME and TNF 7: record_end on the payload length
    // byte, then one ignored byte ending the buffer.
    frame_bytes = '{8'h57, 8'h00, 8'h00, 8'hFF};
    send_frame();
    // Short record with IL and every section, then a long-form record with
    // MB/CF/ME set and a one-byte payload.
    frame_bytes = '{8'h19, 8'h01, 8'h02, 8'h01, 8'h54, 8'h00, 8'hAA, 8'h55,
                    8'hE2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_frame();
    // Buffer ends inside the type section.
    frame_bytes = '{8'h14, 8'h02, 8'h00, 8'h78};
    send_frame();

    // Random segments: max_records swept over its extremes, idle pattern
    // changes every two segments.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       mr = 8'd1;
        1:       mr = 8'd255;
        2:       mr = 8'd0;
        3:       mr = 8'd2;
        4:       mr = 8'($urandom_range(3, 254));
        default: mr = MaxRecordsReset;
      endcase
      write_max_records(mr);
      send_idle_pct  = (seg < 2) ? 6 : (seg < 4) ? 68 : 0;
      recv_stall_pct = (seg < 2) ? 68 : (seg < 4) ? 6 : 0;
      if (seg == 1) begin
        // record index runs past 255 and must saturate; drop starts at 255
        for (int r = 0; r < SatRecords; r++) begin
          push_header(r == SatRecords - 1, 1'b1, 1'b0, 3'($urandom_range(0, 7)),
                      8'd0, 8'd0, 32'd0);
        end
        send_frame();
      end
      seg_goal = bytes_sent + SegBytes;
      while (bytes_sent < seg_goal) send_random_buffer();
    end

    settle();
    $display("%0d bytes checked, %0d buffers, %0d records closed, %0d truncated, %0d ignored",
             tracker.checked, buffers_sent, tracker.records_closed, tracker.truncations,
             tracker.ignored_bytes);
    $display("max_records swept 1/255/0/2/mid/4 under three idle patterns, index saturation hit");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
